// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define SWAC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define SWAC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/swac_pkg.sv =====
// ---------------------------------------------------------------------------
// swac_pkg
// Types and constants shared by the sensor window average check unit.
// ---------------------------------------------------------------------------
package swac_pkg;

  localparam int WINDOW   = 30;
  localparam int VAL_W    = 48;
  localparam int SMP_W    = 32;
  localparam int QCNT_W   = 8;
  localparam int RCNT_W   = 5;
  localparam int DIV_STEPS = VAL_W / 2;   // two quotient bits per cycle
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [QCNT_W-1:0] QCNT_MAX = '1;

  // 99999.0 in Q31.16
  localparam logic signed [VAL_W-1:0] DEFAULT_VAL = 48'sd6553534464;
  // 1000.0 in Q16.16
  localparam logic signed [SMP_W-1:0] LIMIT_RAW     = 32'sd65536000;
  localparam logic signed [SMP_W-1:0] NEG_LIMIT_RAW = -32'sd65536000;

  localparam logic signed [VAL_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

  // Configuration register indexes
  localparam logic [1:0] REG_READ_CODE = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_OFFSET    = 2'd2;

  typedef enum logic [1:0] {
    IN_PREP   = 2'd0,
    IN_TICK   = 2'd1,
    IN_REPLY  = 2'd2,
    IN_UNUSED = 2'd3
  } in_kind_t;

  typedef enum logic [2:0] {
    OUT_DEFAULT = 3'd0,
    OUT_REQUEST = 3'd1,
    OUT_AVERAGE = 3'd2,
    OUT_FAULT   = 3'd3,
    OUT_SAMPLE  = 3'd4
  } out_kind_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SIGN = 6'b010000,
    ST_OUT  = 6'b100000
  } back_state_t;

  typedef struct packed {
    logic [7:0]              read_code;
    logic signed [SMP_W-1:0] gain;
    logic signed [SMP_W-1:0] offset;
  } cfg_t;

  // One classified word between front and back
  typedef struct packed {
    in_kind_t                kind;
    logic signed [SMP_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/sensor_window_average_check_unit.sv =====
// ---------------------------------------------------------------------------
// sensor_window_average_check_unit
// Polling window for a remote sensor with calibrated averaging and fault check.
// ---------------------------------------------------------------------------
// Each input word is a prepare (clear the window, report 99999.0), a query tick
// (count a query; answer with a read request while inside the 30-query window,
// then with the average of the samples or a fault when half or fewer queries
// were answered) or a sensor reply (an IEEE single, converted to Q16.16 with
// saturation, optionally calibrated and added to a saturating 48-bit sum).
// Replies with a foreign function code and replies beyond the window give no
// result. A front end classifies words and converts the float, a two-entry
// queue decouples it from the back end, which executes one command at a time.
// In the back end a prepare or tick goes straight to output, a reply through
// one registered 32x32 multiply and the sum, an average through the divider
// (two quotient bits per cycle over the 48-bit sum) and sign. Results wait in
// an output register, and while a result stalls the front fills the queue.
module sensor_window_average_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] func_code, [39:8] sample_word
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [47:0] value, [52:48] sample_count, pad
  output logic [2:0]  out_tuser,  // [2:0] out_kind
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

`include "assert_macros.svh"

  swac_pkg::cfg_t    cfg_r, cfg_nxt;
  swac_pkg::q_stat_t q_stat;
  swac_pkg::cmd_t    q_wdata, q_rdata;
  logic              q_push, q_pop;

  // Register file: write only; user must write while the block is idle, unchecked
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        swac_pkg::REG_READ_CODE: cfg_nxt.read_code = cfg_wdata[7:0];
        swac_pkg::REG_GAIN:      cfg_nxt.gain      = cfg_wdata;
        swac_pkg::REG_OFFSET:    cfg_nxt.offset    = cfg_wdata;
        default: ;  // no register there, drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_code <= 8'd3;
      cfg_r.gain      <= 32'sd65536;   // 1.0
      cfg_r.offset    <= 32'sd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify and convert
  swac_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Decouple front from back
  swac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  // Execute and report
  swac_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_stat     (q_stat),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `SWAC_ASSERT(a_queue_no_overflow, q_push |-> !q_stat.full, "command pushed into full queue")
  `SWAC_ASSERT(a_count_in_window, out_tvalid |-> (out_tdata[52:48] <= 5'(swac_pkg::WINDOW)), "sample count beyond window")
  `SWAC_ASSERT(a_zero_value, (out_tvalid && (out_tuser == swac_pkg::OUT_REQUEST || out_tuser == swac_pkg::OUT_FAULT)) |-> (out_tdata[47:0] == '0), "request or fault with nonzero value")
  `SWAC_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

// ===== rtl/core/swac_queue.sv =====
// ---------------------------------------------------------------------------
// swac_queue
// Two-entry command queue between the front and back halves.
// ---------------------------------------------------------------------------
module swac_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swac_pkg::cmd_t    push_data,
  input  logic              pop,
  output swac_pkg::cmd_t    pop_data,
  output swac_pkg::q_stat_t stat
);

  swac_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/swac_front.sv =====
// ---------------------------------------------------------------------------
// swac_front
// Accept input words, drop unused kinds and foreign replies, convert the
// reply float to Q16.16 and push the command into the queue.
// ---------------------------------------------------------------------------
module swac_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // [7:0] func_code, [39:8] sample_word
  input  logic [1:0]        in_tuser,   // [1:0] kind
  input  swac_pkg::cfg_t    cfg,
  input  swac_pkg::q_stat_t q_stat,
  output logic              q_push,
  output swac_pkg::cmd_t    q_data
);

  // IEEE single to signed Q16.16, truncate toward zero, saturate
  function automatic logic signed [31:0] float_to_q16(input logic [31:0] w);
    logic [7:0]  e;
    logic [23:0] m;
    logic [30:0] mag;
    logic [7:0]  up_sh;
    logic [7:0]  dn_sh;
    logic signed [31:0] res;
    e     = w[30:23];
    m     = {1'b1, w[22:0]};
    up_sh = e - 8'd134;
    dn_sh = 8'd134 - e;
    mag   = '0;
    if (e == 8'hFF) begin
      res = (w[22:0] != '0) ? 32'sd0 : (w[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    end else if (e == 8'd0 || e <= 8'd110) begin
      res = 32'sd0;
    end else if (e >= 8'd142) begin
      res = w[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      if (e >= 8'd134) begin
        mag = {7'd0, m} << up_sh[2:0];
      end else begin
        mag = {7'd0, m} >> dn_sh[4:0];
      end
      res = w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    return res;
  endfunction

  swac_pkg::in_kind_t kind;
  logic               keep;

  assign kind      = swac_pkg::in_kind_t'(in_tuser);
  assign in_tready = !q_stat.full;

  always_comb begin
    case (kind)
      swac_pkg::IN_PREP:  keep = 1'b1;
      swac_pkg::IN_TICK:  keep = 1'b1;
      swac_pkg::IN_REPLY: keep = (in_tdata[7:0] == cfg.read_code);
      default:            keep = 1'b0;
    endcase
  end

  assign q_push        = in_tvalid && in_tready && keep;
  assign q_data.kind   = kind;
  assign q_data.sample = float_to_q16(in_tdata[39:8]);

endmodule

// ===== rtl/core/swac_back.sv =====
// ---------------------------------------------------------------------------
// swac_back
// Execute queued commands: window counters, calibration, saturating sum,
// iterative average divide, and the registered result port.
// ---------------------------------------------------------------------------
module swac_back (
  input  logic              clk,
  input  logic              rst_n,
  input  swac_pkg::cfg_t    cfg,
  input  swac_pkg::q_stat_t q_stat,
  input  swac_pkg::cmd_t    q_data,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata,  // [47:0] value, [52:48] sample_count
  output logic [2:0]        out_tuser   // [2:0] out_kind
);

  localparam int VW = swac_pkg::VAL_W;

  swac_pkg::back_state_t state_r, state_nxt;
  logic [swac_pkg::QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic [swac_pkg::RCNT_W-1:0] rcnt_r, rcnt_nxt;
  logic signed [VW-1:0]        sum_r, sum_nxt;
  logic signed [31:0]          x_r, x_nxt;
  logic signed [63:0]          prod_r, prod_nxt;
  swac_pkg::out_kind_t         res_kind_r, res_kind_nxt;
  logic signed [VW-1:0]        res_val_r, res_val_nxt;
  logic [VW-1:0]               div_q_r, div_q_nxt;
  logic [swac_pkg::RCNT_W-1:0] div_rem_r, div_rem_nxt;
  logic                        div_neg_r, div_neg_nxt;
  logic [swac_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  swac_pkg::out_kind_t         out_kind_r, out_kind_nxt;
  logic signed [VW-1:0]        out_val_r, out_val_nxt;
  logic [swac_pkg::RCNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic signed [31:0] gain_s, offset_s;
  logic               use_cal;
  logic [swac_pkg::QCNT_W-1:0] qc_new;
  logic signed [VW-1:0] cal_val, x_val;
  logic signed [VW:0]   sum_wide;

  assign gain_s   = cfg.gain;
  assign offset_s = cfg.offset;
  assign use_cal  = (gain_s > swac_pkg::NEG_LIMIT_RAW) && (gain_s < swac_pkg::LIMIT_RAW) &&
                    (offset_s > swac_pkg::NEG_LIMIT_RAW) && (offset_s < swac_pkg::LIMIT_RAW);
  assign qc_new   = (qcnt_r == swac_pkg::QCNT_MAX) ? qcnt_r : qcnt_r + 1'b1;
  assign cal_val  = prod_r[63:16] + {{(VW-32){offset_s[31]}}, offset_s};
  assign x_val    = use_cal ? cal_val : {{(VW-32){x_r[31]}}, x_r};
  assign sum_wide = {sum_r[VW-1], sum_r} + {x_val[VW-1], x_val};

  always_comb begin
    logic [VW-1:0]               q_tmp;
    logic [swac_pkg::RCNT_W-1:0] rem_tmp;
    logic [swac_pkg::RCNT_W:0]   r_try;

    state_nxt     = state_r;
    qcnt_nxt      = qcnt_r;
    rcnt_nxt      = rcnt_r;
    sum_nxt       = sum_r;
    x_nxt         = x_r;
    prod_nxt      = prod_r;
    res_kind_nxt  = res_kind_r;
    res_val_nxt   = res_val_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_neg_nxt   = div_neg_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    q_pop         = 1'b0;
    q_tmp         = div_q_r;
    rem_tmp       = div_rem_r;
    r_try         = '0;

    case (state_r)
      swac_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          x_nxt = q_data.sample;
          case (q_data.kind)
            swac_pkg::IN_PREP: begin
              qcnt_nxt     = '0;
              rcnt_nxt     = '0;
              sum_nxt      = '0;
              res_kind_nxt = swac_pkg::OUT_DEFAULT;
              res_val_nxt  = swac_pkg::DEFAULT_VAL;
              state_nxt    = swac_pkg::ST_OUT;
            end
            swac_pkg::IN_TICK: begin
              qcnt_nxt    = qc_new;
              res_val_nxt = '0;
              if (qc_new <= swac_pkg::QCNT_W'(swac_pkg::WINDOW)) begin
                res_kind_nxt = swac_pkg::OUT_REQUEST;
                state_nxt    = swac_pkg::ST_OUT;
              end else if ({3'd0, rcnt_r} > {1'b0, qc_new[7:1]}) begin
                res_kind_nxt = swac_pkg::OUT_AVERAGE;
                if (rcnt_r == '0) begin
                  state_nxt = swac_pkg::ST_OUT;
                end else begin
                  // load the magnitude of the sum as dividend
                  div_neg_nxt = sum_r[VW-1];
                  div_q_nxt   = sum_r[VW-1] ? VW'(-sum_r) : VW'(sum_r);
                  div_rem_nxt = '0;
                  div_cnt_nxt = '0;
                  state_nxt   = swac_pkg::ST_DIV;
                end
              end else begin
                res_kind_nxt = swac_pkg::OUT_FAULT;
                state_nxt    = swac_pkg::ST_OUT;
              end
            end
            swac_pkg::IN_REPLY: begin
              // drop replies beyond the window
              if (rcnt_r < swac_pkg::RCNT_W'(swac_pkg::WINDOW)) begin
                state_nxt = swac_pkg::ST_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      swac_pkg::ST_MUL: begin
        prod_nxt  = gain_s * x_r;
        state_nxt = swac_pkg::ST_ACC;
      end
      swac_pkg::ST_ACC: begin
        if (sum_wide[VW] != sum_wide[VW-1]) begin
          sum_nxt = sum_wide[VW] ? swac_pkg::SUM_MIN : swac_pkg::SUM_MAX;
        end else begin
          sum_nxt = sum_wide[VW-1:0];
        end
        rcnt_nxt     = rcnt_r + 1'b1;
        res_kind_nxt = swac_pkg::OUT_SAMPLE;
        res_val_nxt  = x_val;
        state_nxt    = swac_pkg::ST_OUT;
      end
      swac_pkg::ST_DIV: begin
        for (int i = 0; i < 2; i++) begin
          r_try = {rem_tmp, q_tmp[VW-1]};
          q_tmp = {q_tmp[VW-2:0], 1'b0};
          if (r_try >= {1'b0, rcnt_r}) begin
            rem_tmp  = swac_pkg::RCNT_W'(r_try - {1'b0, rcnt_r});
            q_tmp[0] = 1'b1;
          end else begin
            rem_tmp = r_try[swac_pkg::RCNT_W-1:0];
          end
        end
        div_q_nxt   = q_tmp;
        div_rem_nxt = rem_tmp;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == swac_pkg::DIV_CNT_W'(swac_pkg::DIV_STEPS - 1)) begin
          state_nxt = swac_pkg::ST_SIGN;
        end
      end
      swac_pkg::ST_SIGN: begin
        res_val_nxt = div_neg_r ? -$signed(div_q_r) : $signed(div_q_r);
        state_nxt   = swac_pkg::ST_OUT;
      end
      swac_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_val_nxt   = res_val_r;
          out_cnt_nxt   = rcnt_r;
          state_nxt     = swac_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swac_pkg::ST_IDLE;
      qcnt_r      <= '0;
      rcnt_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qcnt_r      <= qcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    prod_r     <= prod_nxt;
    res_kind_r <= res_kind_nxt;
    res_val_r  <= res_val_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_neg_r  <= div_neg_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_kind_r <= out_kind_nxt;
    out_val_r  <= out_val_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'd0, out_cnt_r, out_val_r};

endmodule

// ===== test/sensor_window_average_check_unit_tb.sv =====
// ============================================================================
// Sensor window average check unit testbench
// Streams prepare, tick and reply words into the unit and compares every
// result word, field by field, against a cycle-free model of the polling
// window kept inside this bench. Runs directed float corner cases, random
// well-formed windows across several calibration settings and idle patterns,
// query count saturation and random noise words.
// ============================================================================
module sensor_window_average_check_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  // Settle time after the last expected result: covers the divider plus queue.
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS = 200;

  // One expected result word.
  typedef struct {
    swac_pkg::out_kind_t kind;
    logic [47:0]         value;
    logic [4:0]          count;
  } report_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [7:0] func_code, [39:8] sample_word
  logic [1:0]  in_tuser;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [47:0] value, [52:48] sample_count, pad
  logic [2:0]  out_tuser;  // [2:0] out_kind
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // Window model state and its copy of the registers.
  logic [7:0]  win_queries;
  logic [4:0]  win_replies;
  longint      win_sum;
  logic [7:0]  win_read_code;
  int          win_gain;
  int          win_offset;

  report_t     expected_reports[$];
  int          mismatch_count;
  int          hang_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  sensor_window_average_check_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Window model: advance the state for one accepted word and return whether
  // it produces a result word.
  // --------------------------------------------------------------------------
  function automatic bit predict_window_result(input swac_pkg::in_kind_t kind,
                                               input logic [7:0] code,
                                               input logic [31:0] word,
                                               output report_t rpt);
    logic [7:0] expo;
    int         sh;
    longint     x;
    longint     g;
    longint     o;

    rpt.value = '0;
    case (kind)
      swac_pkg::IN_PREP: begin
        win_queries = '0;
        win_replies = '0;
        win_sum     = 0;
        rpt.kind    = swac_pkg::OUT_DEFAULT;
        rpt.value   = swac_pkg::DEFAULT_VAL;
      end
      swac_pkg::IN_TICK: begin
        // Saturate the query count instead of wrapping.
        if (win_queries != swac_pkg::QCNT_MAX) win_queries++;
        if (win_queries <= swac_pkg::WINDOW) begin
          rpt.kind = swac_pkg::OUT_REQUEST;
        end else if (win_replies > win_queries / 2) begin
          rpt.kind = swac_pkg::OUT_AVERAGE;
          x = 0;
          // Signed divide truncates toward zero.
          if (win_replies != 0) x = win_sum / longint'(win_replies);
          rpt.value = x[47:0];
        end else begin
          rpt.kind = swac_pkg::OUT_FAULT;
        end
      end
      swac_pkg::IN_REPLY: begin
        // Drop foreign function codes and replies past the window.
        if (code != win_read_code || win_replies >= swac_pkg::WINDOW) return 0;
        expo = word[30:23];
        if (expo == 8'hFF) begin
          if (word[22:0] != 0) x = 0;
          else x = word[31] ? -64'sd2147483648 : 64'sd2147483647;
        end else if (expo == 8'h00) begin
          x = 0;
        end else begin
          sh = int'(expo) - 134;
          if (sh >= 8) begin
            x = word[31] ? -64'sd2147483648 : 64'sd2147483647;
          end else if (sh <= -24) begin
            x = 0;
          end else begin
            x = longint'({1'b1, word[22:0]});
            x = (sh >= 0) ? (x << sh) : (x >> (-sh));
            if (word[31]) x = -x;
          end
        end
        g = longint'(win_gain);
        o = longint'(win_offset);
        // Calibrate only when both terms are below 1000.0 in magnitude.
        if ((g < 0 ? -g : g) < longint'(swac_pkg::LIMIT_RAW) &&
            (o < 0 ? -o : o) < longint'(swac_pkg::LIMIT_RAW))
          x = ((g * x) >>> 16) + o;
        win_sum = win_sum + x;
        if (win_sum > longint'(swac_pkg::SUM_MAX)) win_sum = longint'(swac_pkg::SUM_MAX);
        if (win_sum < longint'(swac_pkg::SUM_MIN)) win_sum = longint'(swac_pkg::SUM_MIN);
        win_replies++;
        rpt.kind  = swac_pkg::OUT_SAMPLE;
        rpt.value = x[47:0];
      end
      default: return 0;
    endcase
    rpt.count = win_replies;
    return 1;
  endfunction

  // Mostly normal floats in the interesting range, with raw words and
  // special encodings mixed in.
  function automatic logic [31:0] random_sample();
    logic [31:0] w;
    case ($urandom_range(9))
      0: w = $urandom();
      1: begin
        case ($urandom_range(5))
          0: w = 32'h7F80_0000;
          1: w = 32'hFF80_0000;
          2: w = {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
          3: w = {1'($urandom_range(1)), 8'h00, 23'($urandom)};
          4: w = {1'($urandom_range(1)), 8'd142, 23'($urandom)};
          default: w = {1'($urandom_range(1)), 8'($urandom_range(102, 111)), 23'($urandom)};
        endcase
      end
      default: w = {1'($urandom_range(1)), 8'($urandom_range(110, 150)), 23'($urandom)};
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. Every task starts and ends just after a rising edge.
  // --------------------------------------------------------------------------
  task automatic set_idle(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Present one word, hold it until accepted, then record its result.
  task automatic send_word(input swac_pkg::in_kind_t kind, input logic [7:0] code,
                           input logic [31:0] word);
    report_t rpt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {word, code};
    do @(posedge clk); while (!in_tready);
    if (predict_window_result(kind, code, word, rpt)) expected_reports.push_back(rpt);
  endtask

  // Drop valid, drain all expected results, then let dropped words settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      swac_pkg::REG_READ_CODE: win_read_code = data[7:0];
      swac_pkg::REG_GAIN:      win_gain      = data;
      swac_pkg::REG_OFFSET:    win_offset    = data;
      default: ;
    endcase
  endtask

  // One prepare followed by ticks, each maybe answered, with some noise:
  // foreign-code replies, unused kinds and extra replies.
  task automatic run_window(input int ticks, input int answer_pct, input int noise_pct);
    send_word(swac_pkg::IN_PREP, 8'($urandom), $urandom());
    for (int i = 0; i < ticks; i++) begin
      send_word(swac_pkg::IN_TICK, 8'($urandom), $urandom());
      if ($urandom_range(99) < answer_pct)
        send_word(swac_pkg::IN_REPLY, win_read_code, random_sample());
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: send_word(swac_pkg::IN_REPLY, win_read_code ^ 8'($urandom_range(1, 255)),
                       random_sample());
          1: send_word(swac_pkg::IN_UNUSED, 8'($urandom), $urandom());
          default: send_word(swac_pkg::IN_REPLY, win_read_code, random_sample());
        endcase
      end
    end
  endtask

  function automatic int pick_answer_pct();
    case ($urandom_range(3))
      0: return 25;
      1: return 45;
      2: return 60;
      default: return 95;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Float corners, code mismatch and the unused kind under reset settings.
  task automatic test_directed_cases();
    set_idle(0, 0);
    send_word(swac_pkg::IN_PREP, 8'h00, 32'h0000_0000);
    send_word(swac_pkg::IN_TICK, 8'hFF, 32'hFFFF_FFFF);
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h3F80_0000);   // 1.0
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'hC020_0000);   // -2.5
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h7F80_0000);   // +inf saturates high
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'hFF80_0000);   // -inf saturates low
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h7FC0_0000);   // NaN gives zero
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'hFFFF_FFFF);   // negative NaN
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h0000_0000);   // +0
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h8000_0000);   // -0
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h8000_0001);   // subnormal
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h4700_0000);   // 32768.0, first to saturate
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h46FF_FFFF);   // largest value that fits
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'hCF00_0000);   // -2^31 saturates low
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h3780_0000);   // 2^-16, one LSB
    send_word(swac_pkg::IN_REPLY, 8'd3, 32'h3380_0000);   // 2^-24, truncates to zero
    send_word(swac_pkg::IN_REPLY, 8'd4, 32'h3F80_0000);   // foreign code, dropped
    send_word(swac_pkg::IN_UNUSED, 8'd3, 32'h3F80_0000);  // unused kind, dropped
    send_word(swac_pkg::IN_TICK, 8'h00, 32'h0000_0000);
    send_word(swac_pkg::IN_PREP, 8'hFF, 32'hFFFF_FFFF);
    send_word(swac_pkg::IN_TICK, 8'h55, 32'hAAAA_AAAA);
    wait_idle();
  endtask

  // Average versus fault across every idle pattern, reset calibration.
  task automatic test_window_majority();
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: set_idle(0, 0);
        1: set_idle(87, 0);
        2: set_idle(0, 87);
        default: set_idle(16, 16);
      endcase
      run_window($urandom_range(31, 45), pick_answer_pct(), 8);
      run_window($urandom_range(31, 60), pick_answer_pct(), 8);
    end
    wait_idle();
  endtask

  // Calibration enabled and disabled at and around the 1000.0 limit.
  task automatic test_calibration_settings();
    logic [7:0]  codes[6];
    logic [31:0] gains[6];
    logic [31:0] offsets[6];
    codes   = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'($urandom), 8'($urandom)};
    gains   = '{32'sd65535999, -32'sd65535999, 32'sd65536000, 32'sd65536,
                32'h8000_0000, int'($urandom_range(131071998)) - 65535999};
    offsets = '{-32'sd65535999, 32'sd65535999, 32'sd0, -32'sd65536000,
                32'h7FFF_FFFF, int'($urandom_range(131071998)) - 65535999};
    for (int s = 0; s < 6; s++) begin
      write_reg(swac_pkg::REG_READ_CODE, {24'h0, codes[s]});
      write_reg(swac_pkg::REG_GAIN, gains[s]);
      write_reg(swac_pkg::REG_OFFSET, offsets[s]);
      case (s % 4)
        0: set_idle(0, 0);
        1: set_idle(87, 0);
        2: set_idle(0, 87);
        default: set_idle(16, 16);
      endcase
      run_window($urandom_range(20, 45), pick_answer_pct(), 8);
      wait_idle();
    end
    // Back to unity gain, zero offset and the usual code.
    write_reg(swac_pkg::REG_READ_CODE, 32'd3);
    write_reg(swac_pkg::REG_GAIN, 32'd65536);
    write_reg(swac_pkg::REG_OFFSET, 32'd0);
  endtask

  // Drive the query count into saturation at 255.
  task automatic test_query_saturation();
    set_idle(16, 16);
    run_window(262, 40, 4);
    wait_idle();
  endtask

  // Random kinds, codes and words with no structure.
  task automatic test_random_noise();
    set_idle(16, 16);
    for (int i = 0; i < 60; i++)
      send_word(swac_pkg::in_kind_t'($urandom_range(3)),
                $urandom_range(1) ? win_read_code : 8'($urandom), $urandom());
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stall generator.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: expected no result, got kind=%0d value=%0d count=%0d", $time,
                   out_tuser, $signed(out_tdata[47:0]), out_tdata[52:48]);
      end else begin
        if (out_tuser != expected_reports[0].kind ||
            out_tdata[47:0] != expected_reports[0].value ||
            out_tdata[52:48] != expected_reports[0].count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: mismatch expected kind=%0d value=%0d count=%0d, ",
                      "got kind=%0d value=%0d count=%0d"},
                     $time, expected_reports[0].kind, $signed(expected_reports[0].value),
                     expected_reports[0].count, out_tuser, $signed(out_tdata[47:0]),
                     out_tdata[52:48]);
        end
        void'(expected_reports.pop_front());
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hang watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
               HANG_LIMIT, expected_reports.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    hang_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Registers and window state as they come out of reset.
    win_queries    = '0;
    win_replies    = '0;
    win_sum        = 0;
    win_read_code  = 8'd3;
    win_gain       = 65536;
    win_offset     = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_window_majority();
    test_calibration_settings();
    test_query_saturation();
    test_random_noise();

    wait_idle();
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sensor_window_average_check_unit.f =====
+incdir+rtl/core
rtl/core/swac_pkg.sv
rtl/core/swac_queue.sv
rtl/core/swac_front.sv
rtl/core/swac_back.sv
rtl/core/sensor_window_average_check_unit.sv
test/sensor_window_average_check_unit_tb.sv
